@@ rtl/core/tkbc_pkg.sv @@
// Package for the tilt Kalman balance controller: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package tkbc_pkg;

	localparam int AtanIterations = 16;
	localparam int AtanIdxW = 5;

	localparam logic signed [47:0] QAng      = 48'sd66;
	localparam logic signed [47:0] QBia      = 48'sd197;
	localparam logic signed [47:0] RMeas     = 48'sd19661;
	localparam logic signed [47:0] TurnLim   = 48'sd26214;
	localparam logic signed [47:0] OneQ      = 48'sd65536;
	localparam logic signed [47:0] PiQ       = 48'sd205887;
	localparam logic signed [47:0] ThreeHalfPiQ = 48'sd308832;
	localparam logic signed [47:0] TwoPiQ    = 48'sd411775;
	localparam logic signed [31:0] TiltReset = 32'sd83886;

	localparam logic [2:0] RegPeriod = 3'd0;
	localparam logic [2:0] RegTarget = 3'd1;
	localparam logic [2:0] RegKp     = 3'd2;
	localparam logic [2:0] RegKv     = 3'd3;
	localparam logic [2:0] RegKt     = 3'd4;
	localparam logic [2:0] RegKpt    = 3'd5;
	localparam logic [2:0] RegKvt    = 3'd6;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_M_PRED, ST_A_PRED,
		ST_C_INIT, ST_C_ITER, ST_INNOV,
		ST_D_INIT, ST_D_ITER, ST_D_NEXT,
		ST_M_UPD, ST_A_UPD, ST_M_OUT, ST_A_OUT, ST_FINISH, ST_OUT
	} state_t;

	function automatic logic signed [47:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) return 48'sd2147483647;
		else if (v < -48'sd2147483648) return -48'sd2147483648;
		else return v;
	endfunction

	function automatic logic signed [47:0] clampv(input logic signed [47:0] v,
			input logic signed [47:0] lo, input logic signed [47:0] hi);
		if (v < lo) return lo;
		else if (v > hi) return hi;
		else return v;
	endfunction

	function automatic logic signed [31:0] atan_entry(input logic [AtanIdxW-1:0] i);
		case (i)
			5'd0: return 32'sd51472;
			5'd1: return 32'sd30386;
			5'd2: return 32'sd16055;
			5'd3: return 32'sd8150;
			5'd4: return 32'sd4091;
			5'd5: return 32'sd2047;
			5'd6: return 32'sd1024;
			5'd7: return 32'sd512;
			5'd8: return 32'sd256;
			5'd9: return 32'sd128;
			5'd10: return 32'sd64;
			5'd11: return 32'sd32;
			5'd12: return 32'sd16;
			5'd13: return 32'sd8;
			5'd14: return 32'sd4;
			5'd15: return 32'sd2;
			5'd16: return 32'sd1;
			default: return 32'sd0;
		endcase
	endfunction

endpackage

@@ rtl/core/tilt_kalman_balance_controller.sv @@
// Tilt Kalman balance controller top level: sequencer and one shared multiplier.
// Depends on tkbc_pkg.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid, in_stall, gyro_rate .. turn_rate       | request in
//  output   | out_valid, out_stall, left_drive .. gyro_bias_estimate | result out
//  config   | cfg_we, cfg_index, cfg_data                      | writes in
//
// One shared 40x21 multiplier, two passes per product, then an accumulate step.
// A taken request runs through the rate step, the prediction products, CORDIC
// setup, a 16-step CORDIC, the innovation, division setup, two 48-step
// restoring divisions (skipped when S is not positive), the update products,
// the output products and the finish step; out_valid then rises.
// The next request is taken once the result register has been emptied.
// arst_n clears state, configuration, filter state and counters, not datapath
// registers or outputs. A stalled result holds in the output register.
`timescale 1ns / 1ps
module tilt_kalman_balance_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] gyro_rate,
	input  logic signed [23:0] accel_y,
	input  logic signed [23:0] accel_z,
	input  logic signed [23:0] wheel_rate_left,
	input  logic signed [23:0] wheel_rate_right,
	input  logic signed [23:0] heading_error,
	input  logic signed [23:0] turn_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] left_drive,
	output logic signed [17:0] right_drive,
	output logic signed [23:0] tilt_estimate,
	output logic signed [23:0] gyro_bias_estimate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import tkbc_pkg::*;

	typedef logic signed [47:0] w_t;

	state_t state_q, state_d;

	// configuration
	logic [16:0]        dt_q;
	logic signed [19:0] target_q;
	logic signed [23:0] kp_q, kv_q, kt_q, kpt_q, kvt_q;

	// filter state
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;

	// latched request
	logic signed [23:0] gy_q, ay_q, az_q, wl_q, wr_q, te_q, tr_q;

	// working registers
	logic signed [31:0] rate_q, innov_q, k0_q, k1_q;
	w_t                 cx_q, cy_q, cz_q;
	logic [AtanIdxW-1:0] it_q;
	logic [3:0]          op_q;
	logic                mph_q;  // second multiplier pass
	w_t                  acc_q;  // common, then td
	w_t                  hl_q;
	logic [47:0]         rem_q;
	logic [47:0]         num_q;
	logic [47:0]         quo_q;
	logic [32:0]         den_q;
	logic                dneg_q, dsel_q;
	logic [5:0]          dcnt_q;
	logic signed [79:0]  prod_q;

	// multiplier operand select; all operands fit in 40 bits
	w_t ma, mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_M_PRED: begin
				ma = $signed({31'd0, dt_q});
				case (op_q)
					4'd0: mb = w_t'(rate_q);
					4'd1: mb = w_t'(p11_q) - w_t'(p01_q) - w_t'(p10_q) + QAng;
					4'd2: mb = w_t'(p11_q);
					default: mb = QBia;
				endcase
			end
			ST_M_UPD: begin
				case (op_q)
					4'd0: begin ma = w_t'(k0_q); mb = w_t'(innov_q); end
					4'd1: begin ma = w_t'(k1_q); mb = w_t'(innov_q); end
					4'd2: begin ma = w_t'(k1_q); mb = w_t'(p01_q); end
					4'd3: begin ma = w_t'(k1_q); mb = w_t'(p00_q); end
					4'd4: begin ma = w_t'(k0_q); mb = w_t'(p01_q); end
					default: begin ma = w_t'(k0_q); mb = w_t'(p00_q); end
				endcase
			end
			ST_M_OUT: begin
				case (op_q)
					4'd0: begin ma = w_t'(kp_q); mb = w_t'(ang_q) - w_t'(target_q); end
					4'd1: begin ma = w_t'(kt_q); mb = w_t'(rate_q); end
					4'd2: begin ma = w_t'(kv_q); mb = w_t'(wl_q); end
					4'd3: begin ma = w_t'(kv_q); mb = w_t'(wr_q); end
					4'd4: begin ma = w_t'(kpt_q); mb = w_t'(te_q); end
					default: begin ma = w_t'(kvt_q); mb = w_t'(tr_q); end
				endcase
			end
			default: ;
		endcase
	end

	// first pass: unsigned low 20 bits of mb, second pass: signed high 20 bits
	logic signed [20:0] mop;
	logic signed [60:0] pp;
	assign mop = mph_q ? $signed({mb[39], mb[39:20]}) : $signed({1'b0, mb[19:0]});
	assign pp  = $signed(ma[39:0]) * mop;

	w_t pq;
	assign pq = w_t'(prod_q >>> 16);

	// division step
	logic [47:0] rem_sh;
	logic        dfit;
	assign rem_sh = {rem_q[46:0], num_q[47]};
	assign dfit   = rem_sh >= {15'd0, den_q};

	w_t ssum;
	assign ssum = w_t'(p00_q) + RMeas;

	w_t xs, ys;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_RATE;
			ST_RATE:   state_d = ST_M_PRED;
			ST_M_PRED: state_d = mph_q ? ST_A_PRED : ST_M_PRED;
			ST_A_PRED: state_d = (op_q == 4'd3) ? ST_C_INIT : ST_M_PRED;
			ST_C_INIT: state_d = ST_C_ITER;
			ST_C_ITER: if (it_q == AtanIdxW'(AtanIterations - 1)) state_d = ST_INNOV;
			ST_INNOV:  state_d = ST_D_INIT;
			ST_D_INIT: state_d = (ssum > 0) ? ST_D_ITER : ST_M_UPD;
			ST_D_ITER: if (dcnt_q == 6'd47) state_d = ST_D_NEXT;
			ST_D_NEXT: state_d = dsel_q ? ST_M_UPD : ST_D_ITER;
			ST_M_UPD:  state_d = mph_q ? ST_A_UPD : ST_M_UPD;
			ST_A_UPD:  state_d = (op_q == 4'd5) ? ST_M_OUT : ST_M_UPD;
			ST_M_OUT:  state_d = mph_q ? ST_A_OUT : ST_M_OUT;
			ST_A_OUT:  state_d = (op_q == 4'd5) ? ST_FINISH : ST_M_OUT;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT:    if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk)
		prod_q <= mph_q ? prod_q + (80'(pp) <<< 20) : 80'(pp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 17'd262; target_q <= 20'sd83886;
			kp_q <= 24'sd393216; kv_q <= -24'sd7864; kt_q <= -24'sd23593;
			kpt_q <= 24'sd26214; kvt_q <= 24'sd6554;
			ang_q <= TiltReset; bias_q <= '0;
			p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
			op_q <= '0;
			mph_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegPeriod: dt_q <= cfg_data[16:0];
					RegTarget: target_q <= cfg_data[19:0];
					RegKp:  kp_q <= cfg_data;
					RegKv:  kv_q <= cfg_data;
					RegKt:  kt_q <= cfg_data;
					RegKpt: kpt_q <= cfg_data;
					RegKvt: kvt_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q inside {ST_M_PRED, ST_M_UPD, ST_M_OUT}) mph_q <= !mph_q;
			else mph_q <= 1'b0;
			case (state_q)
				ST_RATE: op_q <= '0;
				ST_A_PRED: begin
					case (op_q)
						4'd0: ang_q <= 32'(sat32(w_t'(ang_q) + pq));
						4'd1: p00_q <= 32'(sat32(w_t'(p00_q) + pq));
						4'd2: begin
							p01_q <= 32'(sat32(w_t'(p01_q) - pq));
							p10_q <= 32'(sat32(w_t'(p10_q) - pq));
						end
						default: p11_q <= 32'(sat32(w_t'(p11_q) + pq));
					endcase
					op_q <= (op_q == 4'd3) ? 4'd0 : op_q + 4'd1;
				end
				ST_A_UPD: begin
					case (op_q)
						4'd0: ang_q <= 32'(sat32(w_t'(ang_q) + pq));
						4'd1: bias_q <= 32'(sat32(w_t'(bias_q) + pq));
						4'd2: p11_q <= 32'(sat32(w_t'(p11_q) - pq));
						4'd3: p10_q <= 32'(sat32(w_t'(p10_q) - pq));
						4'd4: p01_q <= 32'(sat32(w_t'(p01_q) - pq));
						default: p00_q <= 32'(sat32(w_t'(p00_q) - pq));
					endcase
					op_q <= (op_q == 4'd5) ? 4'd0 : op_q + 4'd1;
				end
				ST_A_OUT: op_q <= (op_q == 4'd5) ? 4'd0 : op_q + 4'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				gy_q <= gyro_rate; ay_q <= accel_y; az_q <= accel_z;
				wl_q <= wheel_rate_left; wr_q <= wheel_rate_right;
				te_q <= heading_error; tr_q <= turn_rate;
			end
			ST_RATE: rate_q <= 32'(sat32(w_t'(gy_q) - w_t'(bias_q)));
			ST_C_INIT: begin
				it_q <= '0;
				if (az_q < 0) begin
					cz_q <= (ay_q >= 0) ? PiQ : -PiQ;
					cx_q <= -w_t'(az_q); cy_q <= -w_t'(ay_q);
				end else begin
					cz_q <= '0; cx_q <= w_t'(az_q); cy_q <= w_t'(ay_q);
				end
			end
			ST_C_ITER: begin
				it_q <= it_q + 1'b1;
				if (cy_q > 0) begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs;
					cz_q <= cz_q + w_t'(atan_entry(it_q));
				end else begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs;
					cz_q <= cz_q - w_t'(atan_entry(it_q));
				end
			end
			ST_INNOV: begin : innov_blk
				w_t z, d;
				z = (ay_q == 0 && az_q == 0) ? w_t'(0) : cz_q;
				d = z - w_t'(ang_q);
				if (d > ThreeHalfPiQ) d = d - TwoPiQ;
				else if (d < -ThreeHalfPiQ) d = d + TwoPiQ;
				innov_q <= 32'(sat32(d));
			end
			ST_D_INIT: begin
				k0_q <= '0; k1_q <= '0;
				den_q <= ssum[32:0];
				dsel_q <= 1'b0;
				dneg_q <= p00_q[31];
				num_q <= {p00_q[31] ? 32'(-p00_q) : 32'(p00_q), 16'd0};
				rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
			end
			ST_D_ITER: begin
				dcnt_q <= dcnt_q + 6'd1;
				num_q <= {num_q[46:0], 1'b0};
				rem_q <= dfit ? rem_sh - {15'd0, den_q} : rem_sh;
				quo_q <= {quo_q[46:0], dfit};
			end
			ST_D_NEXT: begin : dn_blk
				w_t q;
				// quotient beyond 32 bits only needs its sign to saturate
				if (|quo_q[47:32])
					q = dneg_q ? -48'sd4294967296 : 48'sd4294967296;
				else
					q = dneg_q ? -w_t'({16'd0, quo_q[31:0]}) : w_t'({16'd0, quo_q[31:0]});
				if (!dsel_q) k0_q <= 32'(sat32(q));
				else k1_q <= 32'(sat32(q));
				dsel_q <= 1'b1;
				dneg_q <= p10_q[31];
				num_q <= {p10_q[31] ? 32'(-p10_q) : 32'(p10_q), 16'd0};
				rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
			end
			ST_A_OUT: begin
				case (op_q)
					4'd0: acc_q <= pq;
					4'd1: acc_q <= acc_q - pq;
					4'd2: hl_q <= (acc_q - pq) >>> 1;
					4'd3: acc_q <= (acc_q - pq) >>> 1;
					4'd4: cx_q <= pq;
					default: cy_q <= clampv(cx_q - pq, -TurnLim, TurnLim);
				endcase
			end
			ST_FINISH: begin
				left_drive <= 18'(clampv(hl_q + cy_q, -OneQ, OneQ));
				right_drive <= 18'(clampv(acc_q - cy_q, -OneQ, OneQ));
				tilt_estimate <= 24'(clampv(w_t'(ang_q), -48'sd8388608, 48'sd8388607));
				gyro_bias_estimate <=
					24'(clampv(w_t'(bias_q), -48'sd8388608, 48'sd8388607));
			end
			default: ;
		endcase
	end

endmodule
